// File: hdl/rbsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_pkg
// shared constants and types for the ray / box slab intersection unit
// ----------------------------------------------------------------------------
package rbsi_pkg;

    localparam int Q_W       = 32;
    localparam int FRAC_W    = 16;
    localparam int DIFF_W    = Q_W + 1;
    localparam int REM_W     = DIFF_W + FRAC_W;
    localparam int QUO_STEPS = Q_W - 1;
    // diff stage + overflow stage + one stage per quotient bit + output stage
    localparam int DIV_LAT   = QUO_STEPS + 3;

    localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

    localparam int IN_TDATA_W  = 12 * Q_W;
    localparam int OUT_TDATA_W = 72;

    // per-axis side information that bypasses the dividers
    typedef struct packed {
        logic dir_zero;
        logic in_slab;
    } axis_side_t;

    typedef struct packed {
        logic signed [Q_W-1:0] tn;
        logic signed [Q_W-1:0] tf;
        logic                  miss;
    } slab_t;

endpackage

// File: hdl/ray_box_slab_intersect_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_unit
// ray versus axis-aligned box slab test in Q16.16, fully pipelined
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  s_*     | in  | origin xyz, dir xyz, box_lo xyz, box_hi xyz (12 x 32 bit)
//  m_*     | out | hit, t_near, t_far
//
//  one request accepted per cycle unless the output stalls; each request passes
//  the six bit-per-stage quotient pipelines (31 quotient stages each)
//  aresetn clears all valid bits; payload registers are not reset
//  the whole pipeline advances only while the output register is empty or
//  being taken, so a stall holds every stage in place
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, box_lo_x, box_lo_y,
    // box_lo_z, box_hi_x, box_hi_y, box_hi_z (32 bits each, lowest first)
    input  logic [rbsi_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // hit [0], t_near [32:1], t_far [64:33], zero fill [71:65]
    output logic [rbsi_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import rbsi_pkg::*;

    logic en;

    logic signed [Q_W-1:0] org    [0:2];
    logic signed [Q_W-1:0] dvec   [0:2];
    logic signed [Q_W-1:0] blo    [0:2];
    logic signed [Q_W-1:0] bhi    [0:2];
    logic signed [Q_W-1:0] q_lo   [0:2];
    logic signed [Q_W-1:0] q_hi   [0:2];
    axis_side_t            side_in [0:2];

    axis_side_t            side_reg [0:DIV_LAT-1][0:2];
    logic                  vld_reg  [0:DIV_LAT-1];

    slab_t                 p1_next  [0:2];
    slab_t                 p1_reg   [0:2];
    logic                  p1_vld_reg;

    logic signed [Q_W-1:0] p2_tn_next, p2_tf_next;
    logic                  p2_rej_next;
    logic signed [Q_W-1:0] p2_tn_reg, p2_tf_reg;
    logic                  p2_rej_reg;
    slab_t                 p2_z_reg;
    logic                  p2_vld_reg;

    logic signed [Q_W-1:0] fin_tn, fin_tf;
    logic                  fin_rej;
    logic                  m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_next;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        assign org[a]  = s_tdata[(0 + a) * Q_W +: Q_W];
        assign dvec[a] = s_tdata[(3 + a) * Q_W +: Q_W];
        assign blo[a]  = s_tdata[(6 + a) * Q_W +: Q_W];
        assign bhi[a]  = s_tdata[(9 + a) * Q_W +: Q_W];

        assign side_in[a].dir_zero = (dvec[a] == '0);
        assign side_in[a].in_slab  = (org[a] >= blo[a]) && (org[a] <= bhi[a]);

        rbsi_slab_div u_div_lo (
            .aclk   (aclk),
            .en     (en),
            .corner (blo[a]),
            .origin (org[a]),
            .dir    (dvec[a]),
            .quot   (q_lo[a])
        );

        rbsi_slab_div u_div_hi (
            .aclk   (aclk),
            .en     (en),
            .corner (bhi[a]),
            .origin (org[a]),
            .dir    (dvec[a]),
            .quot   (q_hi[a])
        );

        // order the slab, zero direction gives an unbounded slab or a miss
        always_comb begin
            if (side_reg[DIV_LAT-1][a].dir_zero) begin
                p1_next[a].tn   = Q_MIN;
                p1_next[a].tf   = Q_MAX;
                p1_next[a].miss = !side_reg[DIV_LAT-1][a].in_slab;
            end else begin
                p1_next[a].tn   = (q_lo[a] > q_hi[a]) ? q_hi[a] : q_lo[a];
                p1_next[a].tf   = (q_lo[a] > q_hi[a]) ? q_lo[a] : q_hi[a];
                p1_next[a].miss = 1'b0;
            end
        end
    end

    // side flags and valid bits ride alongside the dividers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIV_LAT; i++) begin
                vld_reg[i] <= 1'b0;
            end
            p1_vld_reg   <= 1'b0;
            p2_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < DIV_LAT; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
            p1_vld_reg   <= vld_reg[DIV_LAT-1];
            p2_vld_reg   <= p1_vld_reg;
            m_tvalid_reg <= p2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                side_reg[0][a] <= side_in[a];
                for (int i = 1; i < DIV_LAT; i++) begin
                    side_reg[i][a] <= side_reg[i-1][a];
                end
                p1_reg[a] <= p1_next[a];
            end
        end
    end

    // intersect x with y
    always_comb begin
        p2_rej_next = p1_reg[0].miss || p1_reg[1].miss
                   || (p1_reg[0].tn > p1_reg[1].tf) || (p1_reg[1].tn > p1_reg[0].tf);
        p2_tn_next  = (p1_reg[1].tn > p1_reg[0].tn) ? p1_reg[1].tn : p1_reg[0].tn;
        p2_tf_next  = (p1_reg[1].tf < p1_reg[0].tf) ? p1_reg[1].tf : p1_reg[0].tf;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_tn_reg  <= p2_tn_next;
            p2_tf_reg  <= p2_tf_next;
            p2_rej_reg <= p2_rej_next;
            p2_z_reg   <= p1_reg[2];
        end
    end

    // intersect with z and format the result
    always_comb begin
        fin_rej = p2_rej_reg || p2_z_reg.miss
               || (p2_tn_reg > p2_z_reg.tf) || (p2_z_reg.tn > p2_tf_reg);
        fin_tn  = (p2_z_reg.tn > p2_tn_reg) ? p2_z_reg.tn : p2_tn_reg;
        fin_tf  = (p2_z_reg.tf < p2_tf_reg) ? p2_z_reg.tf : p2_tf_reg;
        m_tdata_next = '0;
        if (!fin_rej) begin
            m_tdata_next[0]          = (fin_tf > 0);
            m_tdata_next[Q_W:1]      = fin_tn;
            m_tdata_next[2*Q_W:Q_W+1] = fin_tf;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    a_hit_ahead: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> ($signed(m_tdata[2*Q_W:Q_W+1]) > 0)
            && ($signed(m_tdata[Q_W:1]) <= $signed(m_tdata[2*Q_W:Q_W+1])))
        else $error("hit reported with empty or non-positive interval");

    a_stall_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken while output stalled");

    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("output valid right after reset");

    a_fill_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OUT_TDATA_W-1:2*Q_W+1] == '0))
        else $error("fill bits not zero");

endmodule

// File: hdl/rbsi_slab_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_slab_div
// pipelined slab quotient ((corner - origin) << 16) / dir, truncated toward
// zero and saturated to Q16.16, one quotient bit per stage
// ----------------------------------------------------------------------------
module rbsi_slab_div (
    input  logic                               aclk,
    input  logic                               en,
    input  logic signed [rbsi_pkg::Q_W-1:0]    corner,
    input  logic signed [rbsi_pkg::Q_W-1:0]    origin,
    input  logic signed [rbsi_pkg::Q_W-1:0]    dir,
    output logic signed [rbsi_pkg::Q_W-1:0]    quot
);
    import rbsi_pkg::*;

    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        amag_next;
    logic [Q_W-1:0]           adiv_next;
    logic                     aneg_next;
    logic [DIFF_W-1:0]        amag_reg;
    logic [Q_W-1:0]           adiv_reg;
    logic                     aneg_reg;

    logic [REM_W-1:0]         r_reg   [0:QUO_STEPS];
    logic [QUO_STEPS-1:0]     q_reg   [0:QUO_STEPS];
    logic [Q_W-1:0]           d_reg   [0:QUO_STEPS];
    logic                     neg_reg [0:QUO_STEPS];
    logic                     ovf_reg [0:QUO_STEPS];

    logic [63:0]              num_ext;
    logic [63:0]              lim_ext;
    logic [Q_W-1:0]           qmag;
    logic signed [Q_W-1:0]    quot_next;

    // magnitudes and quotient sign
    always_comb begin
        diff      = {corner[Q_W-1], corner} - {origin[Q_W-1], origin};
        amag_next = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
        adiv_next = dir[Q_W-1] ? (~dir + Q_W'(1)) : dir;
        aneg_next = diff[DIFF_W-1] ^ dir[Q_W-1];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            amag_reg <= amag_next;
            adiv_reg <= adiv_next;
            aneg_reg <= aneg_next;
        end
    end

    // magnitude >= 2^31 saturates either way
    always_comb begin
        num_ext = {15'b0, amag_reg, {FRAC_W{1'b0}}};
        lim_ext = {1'b0, adiv_reg, {QUO_STEPS{1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]   <= {amag_reg, {FRAC_W{1'b0}}};
            q_reg[0]   <= '0;
            d_reg[0]   <= adiv_reg;
            neg_reg[0] <= aneg_reg;
            ovf_reg[0] <= (num_ext >= lim_ext);
        end
    end

    for (genvar k = 0; k < QUO_STEPS; k++) begin : g_step
        localparam int SH = QUO_STEPS - 1 - k;
        logic [63:0]      dsh;
        logic [63:0]      r64;
        logic [63:0]      rsub;
        logic             ge;
        logic [REM_W-1:0] r_next;
        logic [QUO_STEPS-1:0] q_next;

        always_comb begin
            dsh    = {32'b0, d_reg[k]} << SH;
            r64    = {15'b0, r_reg[k]};
            rsub   = r64 - dsh;
            ge     = (r64 >= dsh);
            r_next = ge ? rsub[REM_W-1:0] : r_reg[k];
            q_next = q_reg[k];
            q_next[SH] = ge;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[k+1]   <= r_next;
                q_reg[k+1]   <= q_next;
                d_reg[k+1]   <= d_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    always_comb begin
        qmag = {1'b0, q_reg[QUO_STEPS]};
        if (ovf_reg[QUO_STEPS]) begin
            quot_next = neg_reg[QUO_STEPS] ? Q_MIN : Q_MAX;
        end else begin
            quot_next = neg_reg[QUO_STEPS] ? $signed(~qmag + Q_W'(1)) : $signed(qmag);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quot <= quot_next;
        end
    end

endmodule

// File: bench/rbsi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_checker
// watches both channels of the slab intersection unit, predicts each result
// from the accepted request and compares it field by field
// ----------------------------------------------------------------------------
module rbsi_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [rbsi_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [rbsi_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output int                                fail_count,
    output int                                pending_count
);
    import rbsi_pkg::*;

    logic [OUT_TDATA_W-1:0] expected_hits[$];

    function automatic longint sat_q16(longint v);
        if (v > longint'(Q_MAX)) return longint'(Q_MAX);
        if (v < longint'(Q_MIN)) return longint'(Q_MIN);
        return v;
    endfunction

    // full slab test on one request, packed the way m_tdata carries it
    function automatic logic [OUT_TDATA_W-1:0] slab_result(
        logic [IN_TDATA_W-1:0] req);
        longint o, d, lo, hi, a, b, sw, near_t, far_t;
        bit ok;
        logic [OUT_TDATA_W-1:0] r;
        ok = 1;
        near_t = 0;
        far_t = 0;
        for (int ax = 0; ax < 3 && ok; ax++) begin
            o  = longint'($signed(req[ax*Q_W +: Q_W]));
            d  = longint'($signed(req[(3+ax)*Q_W +: Q_W]));
            lo = longint'($signed(req[(6+ax)*Q_W +: Q_W]));
            hi = longint'($signed(req[(9+ax)*Q_W +: Q_W]));
            if (d == 0) begin
                if (o < lo || o > hi) begin
                    ok = 0;
                    continue;
                end
                a = longint'(Q_MIN);
                b = longint'(Q_MAX);
            end else begin
                a = sat_q16(((lo - o) * 65536) / d);
                b = sat_q16(((hi - o) * 65536) / d);
                if (a > b) begin
                    sw = a; a = b; b = sw;
                end
            end
            if (ax == 0) begin
                near_t = a;
                far_t = b;
            end else if (near_t > b || a > far_t) begin
                ok = 0;
            end else begin
                if (a > near_t) near_t = a;
                if (b < far_t) far_t = b;
            end
        end
        r = '0;
        if (ok) begin
            r[0] = far_t > 0;
            r[32:1] = near_t[31:0];
            r[64:33] = far_t[31:0];
        end
        return r;
    endfunction

    initial pending_count = 0;

    always @(posedge aclk) begin
        logic [OUT_TDATA_W-1:0] want;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_hits.push_back(slab_result(s_tdata));
            if (m_tvalid && m_tready) begin
                if (expected_hits.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_hits.pop_front();
                    if (want[0] !== m_tdata[0] || want[32:1] !== m_tdata[32:1]
                        || want[64:33] !== m_tdata[64:33]) begin
                        if (fail_count < 10)
                            $display("result mismatch: hit %b/%b near %h/%h far %h/%h",
                                want[0], m_tdata[0], want[32:1], m_tdata[32:1],
                                want[64:33], m_tdata[64:33]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        pending_count <= expected_hits.size();
    end
endmodule

// File: bench/tb_ray_box_slab_intersect_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ray_box_slab_intersect_unit
// directed and random ray / box requests with random idling on both sides
// ----------------------------------------------------------------------------
module tb_ray_box_slab_intersect_unit;
    import rbsi_pkg::*;

    logic                    aclk = 0;
    logic                    aresetn = 0;
    logic                    s_tvalid = 0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata = '0;
    logic                    m_tvalid;
    logic                    m_tready = 0;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    int                      fail_count;
    int                      pending_count;
    int                      send_idle_pct = 23;
    int                      recv_idle_pct = 50;
    bit                      hold_off = 0;

    always #2 aclk = ~aclk;

    ray_box_slab_intersect_unit dut (.*);

    rbsi_checker checker_i (.*);

    // random 32-bit corner coordinate, often small so slabs overlap
    function automatic logic [31:0] coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return 32'h7fff_fffc + $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        endcase
    endfunction

    function automatic logic [31:0] dir_comp();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return $urandom;
            2: return $urandom_range(0, 1) ? 32'h1 : 32'hffff_ffff;
            default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        endcase
    endfunction

    function automatic logic [IN_TDATA_W-1:0] random_ray();
        logic [IN_TDATA_W-1:0] r;
        logic [31:0] a, b;
        for (int ax = 0; ax < 3; ax++) begin
            r[ax*32 +: 32] = coord();
            r[(3+ax)*32 +: 32] = dir_comp();
            a = coord();
            b = coord();
            // mostly well-formed boxes, some with lo above hi
            if ($urandom_range(0, 9) != 0 && $signed(a) > $signed(b)) begin
                r[(6+ax)*32 +: 32] = b;
                r[(9+ax)*32 +: 32] = a;
            end else begin
                r[(6+ax)*32 +: 32] = a;
                r[(9+ax)*32 +: 32] = b;
            end
        end
        return r;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_ray(
        logic [31:0] o, logic [31:0] d, logic [31:0] lo, logic [31:0] hi);
        logic [IN_TDATA_W-1:0] r;
        for (int ax = 0; ax < 3; ax++) begin
            r[ax*32 +: 32] = o;
            r[(3+ax)*32 +: 32] = d;
            r[(6+ax)*32 +: 32] = lo;
            r[(9+ax)*32 +: 32] = hi;
        end
        return r;
    endfunction

    // tvalid stays high across back-to-back requests, drops only while idling
    task automatic send_request(logic [IN_TDATA_W-1:0] req);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= req;
        do @(posedge aclk); while (!s_tready);
    endtask

    always @(posedge aclk)
        m_tready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);

    initial begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        logic [IN_TDATA_W-1:0] req;
        int guard;
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: unit box, zero direction in and out of the slab, extremes
        send_request(pack_ray(32'hfffe_0000, 32'h0001_0000, 32'hffff_0000, 32'h0001_0000));
        send_request(pack_ray(32'h0, 32'h0, 32'hffff_0000, 32'h0001_0000));
        send_request(pack_ray(32'h0002_0000, 32'h0, 32'hffff_0000, 32'h0001_0000));
        send_request(pack_ray(32'h0, 32'h0, 32'h0001_0000, 32'hffff_0000));
        send_request(pack_ray(32'h8000_0000, 32'h1, 32'h8000_0000, 32'h7fff_ffff));
        send_request(pack_ray(32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff));
        send_request(pack_ray(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        send_request(pack_ray(32'h0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
        send_request(pack_ray(32'h0002_0000, 32'h0001_0000, 32'hffff_0000, 32'h0001_0000));
        send_request(pack_ray(32'hffff_0000, 32'h0001_0000, 32'h0, 32'h0001_0000));
        send_request(pack_ray(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
        req = pack_ray(32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000);
        req[4*32 +: 32] = 32'hffff_0000;
        send_request(req);
        req = pack_ray(32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000);
        req[(7)*32 +: 32] = 32'h0002_0000;
        req[(10)*32 +: 32] = 32'h0003_0000;
        send_request(req);
        // receiver holds off long enough to fill the pipeline
        hold_off <= 1;
        fork
            begin
                repeat (200) @(posedge aclk);
                hold_off <= 0;
            end
            for (int i = 0; i < 60; i++) send_request(random_ray());
        join
        s_tvalid <= 0;
        @(posedge aclk);
        // sender waits for the pipeline to drain
        while (pending_count != 0) @(posedge aclk);
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 50 : 0;
            recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 23 : 0;
            for (int i = 0; i < 580; i++) send_request(random_ray());
        end
        s_tvalid <= 0;
        @(posedge aclk);
        guard = 0;
        while (pending_count != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (DIV_LAT + 10) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
